// ===== sv/b64le_pkg.sv =====
`default_nettype none
package b64le_pkg;

    localparam int MAX_LINE_GROUPS = 16;
    localparam int FULL_LINE_BYTES = 48;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] LINE_GROUPS_RESET = CFG_W'(FULL_LINE_BYTES / 3);
    localparam logic [CFG_W-1:0] LINE_GROUPS_MAX = CFG_W'(MAX_LINE_GROUPS);

    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;
    localparam logic [CHAR_W-1:0] LF_CHAR = 7'd10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // One output burst: a group of four characters and/or a line feed.
    typedef struct packed {
        logic [23:0] bits;
        logic [2:0]  n_alpha;
        logic        quad;
        logic        lf;
        logic        fin;
    } t_job;

    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 6'd26) begin
            c = 7'd65 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'd71 + {1'b0, v};
        end else if (v < 6'd62) begin
            c = {1'b0, v} - 7'd4;
        end else if (v == 6'd62) begin
            c = 7'd43;
        end else begin
            c = 7'd47;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/b64le_front.sv =====
`default_nettype none
module b64le_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [b64le_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                           i_accept,
    input  wire logic                           i_kind,
    input  wire logic [7:0]                     i_byte,
    output logic                                o_push,
    output b64le_pkg::t_job                     o_job
);

    logic [b64le_pkg::CFG_W-1:0] r_line_groups;
    logic [15:0]                 r_held, n_held;
    logic [1:0]                  r_bg, n_bg;
    logic [4:0]                  r_gl, n_gl;
    logic [4:0]                  gl_inc;
    logic [b64le_pkg::CFG_W-1:0] groups_use;

    always_comb begin
        if (r_line_groups == '0) begin
            groups_use = b64le_pkg::CFG_W'(1);
        end else if (r_line_groups > b64le_pkg::LINE_GROUPS_MAX) begin
            groups_use = b64le_pkg::LINE_GROUPS_MAX;
        end else begin
            groups_use = r_line_groups;
        end
    end

    assign gl_inc = r_gl + 5'd1;

    always_comb begin
        n_held = r_held;
        n_bg   = r_bg;
        n_gl   = r_gl;
        o_push = 1'b0;
        o_job  = '0;
        if (i_accept) begin
            if (i_kind == b64le_pkg::KIND_DATA) begin
                unique case (r_bg)
                    2'd0: begin
                        n_held = {i_byte, 8'h00};
                        n_bg   = 2'd1;
                    end
                    2'd1: begin
                        n_held = {r_held[15:8], i_byte};
                        n_bg   = 2'd2;
                    end
                    default: begin
                        o_push        = 1'b1;
                        o_job.bits    = {r_held, i_byte};
                        o_job.n_alpha = 3'd4;
                        o_job.quad    = 1'b1;
                        o_job.lf      = (gl_inc >= groups_use);
                        o_job.fin     = 1'b0;
                        n_held        = '0;
                        n_bg          = 2'd0;
                        n_gl          = o_job.lf ? 5'd0 : gl_inc;
                    end
                endcase
            end else begin
                if (r_bg != 2'd0 || r_gl != 5'd0) begin
                    o_push        = 1'b1;
                    o_job.bits    = (r_bg == 2'd1) ? {r_held[15:8], 16'h0000}
                                                   : {r_held, 8'h00};
                    o_job.n_alpha = (r_bg == 2'd1) ? 3'd2 : 3'd3;
                    o_job.quad    = (r_bg != 2'd0);
                    o_job.lf      = 1'b1;
                    o_job.fin     = 1'b1;
                end
                n_held = '0;
                n_bg   = 2'd0;
                n_gl   = 5'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_groups <= b64le_pkg::LINE_GROUPS_RESET;
            r_held        <= '0;
            r_bg          <= 2'd0;
            r_gl          <= 5'd0;
        end else begin
            if (i_cfg_we) begin
                r_line_groups <= i_cfg_wdata;
            end
            r_held <= n_held;
            r_bg   <= n_bg;
            r_gl   <= n_gl;
        end
    end

endmodule
`default_nettype wire

// ===== sv/b64le_queue.sv =====
`default_nettype none
module b64le_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire b64le_pkg::t_job    i_job,
    output logic                    o_full,
    output logic                    o_valid,
    output b64le_pkg::t_job         o_job,
    input  wire logic               i_pop
);

    b64le_pkg::t_job                    r_mem [b64le_pkg::QUEUE_DEPTH];
    logic [b64le_pkg::QPTR_W-1:0]       r_wr, r_rd;
    logic [b64le_pkg::QCNT_W-1:0]       r_cnt;
    logic                               do_push, do_pop;

    assign o_full  = (r_cnt == b64le_pkg::QCNT_W'(b64le_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/b64le_back.sv =====
`default_nettype none
module b64le_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire b64le_pkg::t_job                i_job,
    output logic                                o_pop,
    output logic                                o_tvalid,
    input  wire logic                           i_tready,
    output logic [b64le_pkg::CHAR_W-1:0]        o_char,
    output logic                                o_last,
    output logic                                o_end
);

    logic [2:0]                     r_pos;
    logic                           r_valid;
    logic [b64le_pkg::CHAR_W-1:0]   r_char, n_char;
    logic                           r_last, r_end;
    logic [2:0]                     total;
    logic                           is_last, emit;
    logic [5:0]                     sextet;

    assign total   = (i_job.quad ? 3'd4 : 3'd0) + {2'b00, i_job.lf};
    assign is_last = (r_pos == total - 3'd1);
    assign emit    = i_valid && (!r_valid || i_tready);
    assign o_pop   = emit && is_last;

    always_comb begin
        unique case (r_pos[1:0])
            2'd0:    sextet = i_job.bits[23:18];
            2'd1:    sextet = i_job.bits[17:12];
            2'd2:    sextet = i_job.bits[11:6];
            default: sextet = i_job.bits[5:0];
        endcase
        if (i_job.quad && r_pos < 3'd4) begin
            n_char = (r_pos < i_job.n_alpha) ? b64le_pkg::b64_char(sextet)
                                             : b64le_pkg::PAD_CHAR;
        end else begin
            n_char = b64le_pkg::LF_CHAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= n_char;
            r_last <= is_last;
            r_end  <= is_last && i_job.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_pos   <= is_last ? 3'd0 : r_pos + 3'd1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_char   = r_char;
    assign o_last   = r_last;
    assign o_end    = r_end;

endmodule
`default_nettype wire

// ===== sv/base64_line_encoder_unit.sv =====
`default_nettype none
// Base64 encoder with line wrap. Bytes enter on the slave stream at up to one per cycle
// while the four-entry job queue has room; every third byte, and every finish that has
// something pending, queues one job of one to five characters. The master stream sends one
// character per cycle while m_axis_tready is high and a job is queued, from a registered
// output stage, so the sustained rate is set by that stage: four characters per three
// bytes plus a line feed per line. i_cfg_wdata sets groups per line (0 acts as 1, above
// 16 as 16); write it only while idle. Reset is synchronous, active low.
module base64_line_encoder_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [b64le_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // data_byte
    input  wire logic                           s_axis_tuser,   // kind
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // out_char, zero bit 7
    output logic                                m_axis_tlast,   // last_of_run
    output logic                                m_axis_tuser    // message_end
);

    logic                           push, full, q_valid, pop;
    b64le_pkg::t_job                push_job, head_job;
    logic [b64le_pkg::CHAR_W-1:0]   out_char;

    assign s_axis_tready = !full;

    b64le_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (s_axis_tvalid && s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .o_push      (push),
        .o_job       (push_job)
    );

    b64le_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    b64le_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_char   (out_char),
        .o_last   (m_axis_tlast),
        .o_end    (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule
`default_nettype wire

// ===== sv/b64le_checker.sv =====
`default_nettype none
module b64le_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output transaction changed");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("message end without end of run");

    a_end_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd10)
        else $error("message end is not a line feed");

    a_last_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'd10
            || (m_axis_tdata != 8'd61 && !m_axis_tuser))
        else $error("run ends on a pad");

endmodule

bind base64_line_encoder_unit b64le_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
